/* rtl/mnt_pkg.sv */
// ----------------------------------------------------------------------------
// mnt_pkg
// Shared constants, codes and control types of the mesh node table.
// ----------------------------------------------------------------------------
package mnt_pkg;

  localparam int NODE_SLOTS = 16;
  localparam int IDX_W      = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;

  localparam int ID_W       = 64;
  localparam int ADDR_IN_W  = 16;
  localparam int ADDR_W     = 15;
  localparam int ELEM_W     = 8;
  localparam int ENTRY_W    = 4;
  localparam int STATUS_W   = 2;

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 32;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NOT_UNICAST = 2'd1,
    ST_FULL        = 2'd2,
    ST_NOT_FOUND   = 2'd3
  } mnt_status_t;

  typedef struct packed {
    logic        load;       // capture the input word
    logic        idx_clr;    // restart the slot scan
    logic        idx_inc;    // advance to the next slot
    logic        wr_id;      // write the id of the current slot
    logic        wr_fields;  // write address, elements and state of the current slot
    logic        emit;       // load the output register
    logic        emit_entry; // result carries an entry
    logic        emit_req;   // entry fields come from the request, not the slot
    mnt_status_t emit_status;
  } mnt_cmd_t;

  typedef struct packed {
    logic unicast;
    logic lookup;
    logic id_hit;
    logic free_hit;
    logic range_hit;
    logic last;
    logic out_free;
  } mnt_sts_t;

endpackage

/* rtl/mnt_ctrl.sv */
// ----------------------------------------------------------------------------
// mnt_ctrl
// Sequencer of the mesh node table: walks the slots for id match, free slot
// or address range and issues writes and results to the datapath.
// ----------------------------------------------------------------------------
module mnt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mnt_pkg::mnt_sts_t sts,
  output mnt_pkg::mnt_cmd_t cmd
);
  import mnt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_CHECK     = 5'b00010,
    S_ID_SCAN   = 5'b00100,
    S_FREE_SCAN = 5'b01000,
    S_LOOK_SCAN = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.emit_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.unicast) begin
          if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_NOT_UNICAST;
            state_nxt       = S_IDLE;
          end
        end else if (sts.lookup) begin
          state_nxt = S_LOOK_SCAN;
        end else begin
          state_nxt = S_ID_SCAN;
        end
      end
      S_ID_SCAN: begin
        if (sts.id_hit) begin
          if (sts.out_free) begin
            cmd.wr_fields  = 1'b1;
            cmd.emit       = 1'b1;
            cmd.emit_entry = 1'b1;
            cmd.emit_req   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (sts.last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_FREE_SCAN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_FREE_SCAN: begin
        if (sts.free_hit) begin
          if (sts.out_free) begin
            cmd.wr_id      = 1'b1;
            cmd.wr_fields  = 1'b1;
            cmd.emit       = 1'b1;
            cmd.emit_entry = 1'b1;
            cmd.emit_req   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (sts.last) begin
          if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_FULL;
            state_nxt       = S_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_LOOK_SCAN: begin
        if (sts.range_hit) begin
          if (sts.out_free) begin
            cmd.emit       = 1'b1;
            cmd.emit_entry = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (sts.last) begin
          if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_NOT_FOUND;
            state_nxt       = S_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/mnt_datapath.sv */
// ----------------------------------------------------------------------------
// mnt_datapath
// Slot register file, request register, scan counter, slot compares and the
// output register of the mesh node table.
// ----------------------------------------------------------------------------
module mnt_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tuser,
  input  logic [mnt_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mnt_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  mnt_pkg::mnt_cmd_t                  cmd,
  output mnt_pkg::mnt_sts_t                  sts
);
  import mnt_pkg::*;

  logic [ID_W-1:0]      id_hi_r   [NODE_SLOTS];
  logic [ID_W-1:0]      id_lo_r   [NODE_SLOTS];
  logic [ADDR_W-1:0]    base_r    [NODE_SLOTS];
  logic [ELEM_W-1:0]    elems_r   [NODE_SLOTS];
  logic                 onoff_r   [NODE_SLOTS];

  logic                 req_lookup_r;
  logic [ID_W-1:0]      req_id_hi_r;
  logic [ID_W-1:0]      req_id_lo_r;
  logic [ADDR_IN_W-1:0] req_addr_r;
  logic [ELEM_W-1:0]    req_elems_r;
  logic                 req_onoff_r;

  idx_t                 idx_r;

  logic                 out_valid_r;
  mnt_status_t          out_status_r;
  logic [ENTRY_W-1:0]   out_entry_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [ELEM_W-1:0]    out_elems_r;
  logic                 out_state_r;

  logic [ADDR_IN_W-1:0] slot_end;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_lookup_r <= in_tuser;
      req_id_hi_r  <= in_tdata[63:0];
      req_id_lo_r  <= in_tdata[127:64];
      req_addr_r   <= in_tdata[143:128];
      req_elems_r  <= in_tdata[151:144];
      req_onoff_r  <= in_tdata[152];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODE_SLOTS; i++) begin
        id_hi_r[i] <= '0;
        id_lo_r[i] <= '0;
        base_r[i]  <= '0;
        elems_r[i] <= '0;
        onoff_r[i] <= 1'b0;
      end
    end else begin
      if (cmd.wr_id) begin
        id_hi_r[idx_r] <= req_id_hi_r;
        id_lo_r[idx_r] <= req_id_lo_r;
      end
      if (cmd.wr_fields) begin
        base_r[idx_r]  <= req_addr_r[ADDR_W-1:0];
        elems_r[idx_r] <= req_elems_r;
        onoff_r[idx_r] <= req_onoff_r;
      end
    end
  end

  assign slot_end = ADDR_IN_W'(base_r[idx_r]) + ADDR_IN_W'(elems_r[idx_r]);

  always_comb begin
    sts.unicast   = (req_addr_r != '0) && !req_addr_r[ADDR_IN_W-1];
    sts.lookup    = req_lookup_r;
    sts.id_hit    = (id_hi_r[idx_r] == req_id_hi_r) && (id_lo_r[idx_r] == req_id_lo_r);
    sts.free_hit  = (base_r[idx_r] == '0);
    sts.range_hit = (ADDR_IN_W'(base_r[idx_r]) <= req_addr_r) && (slot_end > req_addr_r);
    sts.last      = (idx_r == idx_t'(NODE_SLOTS - 1));
    sts.out_free  = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      if (!cmd.emit_entry) begin
        out_entry_r <= '0;
        out_addr_r  <= '0;
        out_elems_r <= '0;
        out_state_r <= 1'b0;
      end else if (cmd.emit_req) begin
        out_entry_r <= ENTRY_W'(idx_r);
        out_addr_r  <= req_addr_r[ADDR_W-1:0];
        out_elems_r <= req_elems_r;
        out_state_r <= req_onoff_r;
      end else begin
        out_entry_r <= ENTRY_W'(idx_r);
        out_addr_r  <= base_r[idx_r];
        out_elems_r <= elems_r[idx_r];
        out_state_r <= onoff_r[idx_r];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_state_r, out_elems_r, out_addr_r, out_entry_r, out_status_r};

endmodule

/* rtl/mesh_node_table_core.sv */
// ----------------------------------------------------------------------------
// mesh_node_table_core
// Table of mesh nodes keyed by a 128-bit device id, with store or update by
// id and lookup by unicast address range.
//
//   Channel   Direction  Carries
//   in_*      slave      one request word: store by id or look up by address
//   out_*     master     one result word per request
//
// A request whose address is not unicast is answered from the check step. A lookup
// ends at the first slot whose range holds the address, and a store scans first for
// a matching id, then for a free slot; each scan visits one slot of the register
// file per cycle. Reset clears every slot at once.
// A new word is taken while a result still waits on out_tready; the scan holds at
// its final step until the output register is free.
// ----------------------------------------------------------------------------
module mesh_node_table_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic                               in_tuser,  // action
  // uuid_high, uuid_low, address, element_count, onoff, zero fill
  input  logic [mnt_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status, entry_index, node_address, node_elements, node_state, zero fill
  output logic [mnt_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import mnt_pkg::*;

  mnt_cmd_t cmd;
  mnt_sts_t sts;

  mnt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mnt_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
